/* rtl/wti_pkg.sv */
// Shared types and constants of the waypoint trajectory interpolator.
package wti_pkg;

  typedef enum logic [1:0] {
    ACT_WP_WRITE    = 2'd0,
    ACT_START_WRITE = 2'd1,
    ACT_NEW_GOAL    = 2'd2,
    ACT_TICK        = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_INTERP   = 2'd0,
    ST_PAST_END = 2'd1,
    ST_ZERO_SEG = 2'd2,
    ST_EMPTY    = 2'd3
  } status_e;

  localparam int unsigned NCOMP     = 15;
  localparam int unsigned POSE_N    = 7;
  localparam int unsigned DIV_STEPS = 33;

  localparam logic [3:0] COMP_WRENCH0 = 4'd7;
  localparam logic [3:0] COMP_FLAGS   = 4'd13;
  localparam logic [3:0] COMP_TIME    = 4'd14;

  typedef struct packed {
    logic accept;
    logic srch_rd;
    logic srch_chk;
    logic ts_rd;
    logic ts_chk;
    logic ent_rd;
    logic ent_wr;
    logic c_rd;
    logic c_dat;
    logic mul;
    logic div_step;
    logic fin;
    logic emit;
    logic comp_clr;
    logic comp_ent;
    logic comp_inc;
  } cmd_t;

  typedef struct packed {
    logic is_tick;
    logic n_zero;
    logic found;
    logic at_end;
    logic entry_need;
    logic need_interp;
    logic comp_last;
    logic out_free;
  } sts_t;

endpackage

/* rtl/wti_ctrl.sv */
// Sequencer of the interpolator: search, segment entry, per-component compute and output.
module wti_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_valid_i,
  input  wti_pkg::sts_t sts_i,
  output logic          s_ready_o,
  output wti_pkg::cmd_t cmd_o
);

  typedef enum logic [12:0] {
    S_IDLE  = 13'b0000000000001,
    S_S_RD  = 13'b0000000000010,
    S_S_CHK = 13'b0000000000100,
    S_T_RD  = 13'b0000000001000,
    S_T_CHK = 13'b0000000010000,
    S_E_RD  = 13'b0000000100000,
    S_E_WR  = 13'b0000001000000,
    S_C_RD  = 13'b0000010000000,
    S_C_DAT = 13'b0000100000000,
    S_MUL   = 13'b0001000000000,
    S_DIV   = 13'b0010000000000,
    S_FIN   = 13'b0100000000000,
    S_EMIT  = 13'b1000000000000
  } state_e;

  state_e     state_q, state_d;
  logic [5:0] cnt_q, cnt_d;

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    cmd_o     = '0;
    s_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          cmd_o.accept = 1'b1;
          if (sts_i.is_tick) begin
            cmd_o.comp_clr = 1'b1;
            state_d = sts_i.n_zero ? S_C_RD : S_S_RD;
          end
        end
      end
      S_S_RD: begin
        cmd_o.srch_rd = 1'b1;
        state_d = S_S_CHK;
      end
      S_S_CHK: begin
        cmd_o.srch_chk = 1'b1;
        if (sts_i.found) begin
          state_d = S_T_RD;
        end else if (sts_i.at_end) begin
          cmd_o.comp_clr = 1'b1;
          state_d = S_C_RD;
        end else begin
          state_d = S_S_RD;
        end
      end
      S_T_RD: begin
        cmd_o.ts_rd = 1'b1;
        state_d = S_T_CHK;
      end
      S_T_CHK: begin
        cmd_o.ts_chk = 1'b1;
        if (sts_i.entry_need) begin
          cmd_o.comp_ent = 1'b1;
          state_d = S_E_RD;
        end else begin
          cmd_o.comp_clr = 1'b1;
          state_d = S_C_RD;
        end
      end
      S_E_RD: begin
        cmd_o.ent_rd = 1'b1;
        state_d = S_E_WR;
      end
      S_E_WR: begin
        cmd_o.ent_wr = 1'b1;
        if (sts_i.comp_last) begin
          cmd_o.comp_clr = 1'b1;
          state_d = S_C_RD;
        end else begin
          cmd_o.comp_inc = 1'b1;
          state_d = S_E_RD;
        end
      end
      S_C_RD: begin
        cmd_o.c_rd = 1'b1;
        state_d = S_C_DAT;
      end
      S_C_DAT: begin
        cmd_o.c_dat = 1'b1;
        state_d = sts_i.need_interp ? S_MUL : S_EMIT;
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        cnt_d = '0;
        state_d = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'(wti_pkg::DIV_STEPS - 1)) state_d = S_FIN;
      end
      S_FIN: begin
        cmd_o.fin = 1'b1;
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.comp_inc = 1'b1;
          state_d = sts_i.comp_last ? S_IDLE : S_C_RD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

/* rtl/wti_dpath.sv */
// Datapath: waypoint memory, pose registers, segment search compare and serial mul-div.
module wti_dpath #(
  parameter int unsigned WAYPOINTS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  wti_pkg::cmd_t       cmd_i,
  output wti_pkg::sts_t       sts_o,
  input  logic                cfg_we_i,
  input  logic [4:0]          cfg_wdata_i,
  input  logic [1:0]          action_i,
  input  logic [3:0]          slot_i,
  input  logic [3:0]          component_i,
  input  logic [31:0]         value_i,
  input  logic [30:0]         elapsed_i,
  input  logic [6:0][31:0]    actual_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [3:0]          out_component_o,
  output logic [31:0]         out_value_o,
  output logic                out_last_o,
  output logic [1:0]          out_status_o
);

  localparam int unsigned RW  = (WAYPOINTS > 1) ? $clog2(WAYPOINTS) : 1;
  localparam int unsigned CW0 = $clog2(WAYPOINTS + 1);
  localparam int unsigned CW  = (CW0 > 5) ? CW0 : 5;
  localparam int unsigned AW  = RW + 4;

  logic [31:0] mem [WAYPOINTS*16];
  logic [31:0] rdata_q;

  logic [4:0]        pc_q;
  logic              fresh_q;
  logic [31:0]       start_q [wti_pkg::POSE_N];
  logic [31:0]       held_q  [wti_pkg::NCOMP];
  logic [30:0]       t_q;
  logic [31:0]       act_q   [wti_pkg::POSE_N];
  logic [CW-1:0]     n_q, idx_q, row_q;
  logic [3:0]        comp_q;
  wti_pkg::status_e  mode_q;
  logic [31:0]       te_q, d_q, b_q, sv_q, res_q;
  logic              neg_q;
  logic [32:0]       a_q, qr_q;
  logic [31:0]       rem_q;
  logic              out_valid_q, out_last_q;
  logic [3:0]        out_comp_q;
  logic [31:0]       out_val_q;
  logic [1:0]        out_status_q;

  logic [CW-1:0] pc_ext, n_now, prev_row, rd_row;
  logic [3:0]    rd_comp;
  logic          rd_en, wp_wr;
  logic [AW-1:0] raddr, waddr;
  logic [31:0]   ts_v, sv_v, sel_v;
  logic [32:0]   d_full, b_full, diff, a_v, rem2;
  logic [64:0]   prod;
  logic [33:0]   r_v;
  logic          found, zero_seg, pose_c, ge;

  assign pc_ext   = CW'(pc_q);
  assign n_now    = (pc_ext > CW'(WAYPOINTS)) ? CW'(WAYPOINTS) : pc_ext;
  assign prev_row = row_q - CW'(1);
  assign pose_c   = comp_q < 4'(wti_pkg::POSE_N);

  always_comb begin
    rd_en   = 1'b1;
    rd_row  = row_q;
    rd_comp = comp_q;
    priority if (cmd_i.srch_rd) begin
      rd_row  = idx_q;
      rd_comp = wti_pkg::COMP_TIME;
    end else if (cmd_i.ts_rd) begin
      rd_row  = prev_row;
      rd_comp = wti_pkg::COMP_TIME;
    end else if (cmd_i.ent_rd) begin
      rd_row  = prev_row;
    end else if (cmd_i.c_rd) begin
      rd_row  = row_q;
    end else begin
      rd_en   = 1'b0;
    end
  end

  assign raddr = {rd_row[RW-1:0], rd_comp};
  assign waddr = {RW'(slot_i), component_i};
  assign wp_wr = cmd_i.accept && (action_i == wti_pkg::ACT_WP_WRITE) &&
                 (32'(slot_i) < WAYPOINTS) && (component_i < 4'(wti_pkg::NCOMP));

  always_ff @(posedge clk_i) begin
    if (wp_wr) begin
      mem[waddr] <= (component_i == wti_pkg::COMP_FLAGS) ? {26'd0, value_i[5:0]} : value_i;
    end
    if (rd_en) begin
      rdata_q <= mem[raddr];
    end
  end

  assign found    = $signed(rdata_q) >= $signed({1'b0, t_q});
  assign ts_v     = (row_q != '0) ? rdata_q : '0;
  assign d_full   = {te_q[31], te_q} - {ts_v[31], ts_v};
  assign b_full   = {2'b00, t_q} - {ts_v[31], ts_v};
  assign zero_seg = $signed(te_q) <= $signed(ts_v);
  assign sv_v     = (row_q == '0) ? start_q[comp_q[2:0]] : held_q[comp_q];
  assign diff     = {rdata_q[31], rdata_q} - {sv_v[31], sv_v};
  assign a_v      = diff[32] ? (~diff + 33'd1) : diff;
  assign prod     = a_q * b_q;
  assign rem2     = {rem_q, qr_q[32]};
  assign ge       = rem2 >= {1'b0, d_q};
  assign r_v      = neg_q ? ({{2{sv_q[31]}}, sv_q} - {1'b0, qr_q})
                          : ({{2{sv_q[31]}}, sv_q} + {1'b0, qr_q});

  always_comb begin
    unique case (mode_q)
      wti_pkg::ST_EMPTY:    sel_v = held_q[comp_q];
      wti_pkg::ST_PAST_END: sel_v = rdata_q;
      default: begin
        if (pose_c) sel_v = act_q[comp_q[2:0]];
        else if (comp_q == wti_pkg::COMP_TIME) sel_v = {1'b0, t_q};
        else sel_v = rdata_q;
      end
    endcase
  end

  always_comb begin
    sts_o             = '0;
    sts_o.is_tick     = action_i == wti_pkg::ACT_TICK;
    sts_o.n_zero      = n_now == '0;
    sts_o.found       = found;
    sts_o.at_end      = (idx_q + CW'(1)) == n_q;
    sts_o.entry_need  = (row_q != '0) && (held_q[wti_pkg::COMP_TIME] != rdata_q);
    sts_o.need_interp = (mode_q == wti_pkg::ST_INTERP) && pose_c;
    sts_o.comp_last   = comp_q == wti_pkg::COMP_TIME;
    sts_o.out_free    = !out_valid_q || out_ready_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= '0;
      fresh_q     <= 1'b0;
      out_valid_q <= 1'b0;
      mode_q      <= wti_pkg::ST_EMPTY;
      for (int i = 0; i < wti_pkg::POSE_N; i++) start_q[i] <= '0;
      for (int i = 0; i < wti_pkg::NCOMP; i++) held_q[i] <= '0;
    end else begin
      if (cfg_we_i) pc_q <= cfg_wdata_i;
      if (cmd_i.emit) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;

      if (cmd_i.accept) begin
        if (action_i == wti_pkg::ACT_START_WRITE && component_i < 4'(wti_pkg::POSE_N)) begin
          start_q[component_i[2:0]] <= value_i;
        end
        if (action_i == wti_pkg::ACT_NEW_GOAL) fresh_q <= 1'b1;
        if (action_i == wti_pkg::ACT_TICK) begin
          mode_q <= (n_now == '0) ? wti_pkg::ST_EMPTY : wti_pkg::ST_INTERP;
          if (n_now != '0 && fresh_q) begin
            fresh_q <= 1'b0;
            for (int i = 0; i < wti_pkg::POSE_N; i++) held_q[i] <= start_q[i];
            for (int i = wti_pkg::POSE_N; i < wti_pkg::NCOMP; i++) held_q[i] <= '0;
          end
        end
      end
      if (cmd_i.srch_chk && !found && sts_o.at_end) mode_q <= wti_pkg::ST_PAST_END;
      if (cmd_i.ts_chk) begin
        mode_q <= zero_seg ? wti_pkg::ST_ZERO_SEG : wti_pkg::ST_INTERP;
        if (sts_o.entry_need) begin
          for (int i = 0; i < wti_pkg::POSE_N; i++) held_q[i] <= act_q[i];
        end
      end
      if (cmd_i.ent_wr) held_q[comp_q] <= rdata_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && action_i == wti_pkg::ACT_TICK) begin
      t_q   <= elapsed_i;
      n_q   <= n_now;
      idx_q <= '0;
      for (int i = 0; i < wti_pkg::POSE_N; i++) act_q[i] <= actual_i[i];
    end
    if (cmd_i.srch_chk) begin
      if (found) begin
        row_q <= idx_q;
        te_q  <= rdata_q;
      end else if (sts_o.at_end) begin
        row_q <= n_q - CW'(1);
      end else begin
        idx_q <= idx_q + CW'(1);
      end
    end
    if (cmd_i.ts_chk) begin
      d_q <= d_full[31:0];
      b_q <= b_full[31:0];
    end
    if (cmd_i.comp_clr) comp_q <= '0;
    else if (cmd_i.comp_ent) comp_q <= wti_pkg::COMP_WRENCH0;
    else if (cmd_i.comp_inc) comp_q <= comp_q + 4'd1;
    if (cmd_i.c_dat) begin
      res_q <= sel_v;
      sv_q  <= sv_v;
      neg_q <= diff[32];
      a_q   <= a_v;
    end
    if (cmd_i.mul) begin
      rem_q <= prod[64:33];
      qr_q  <= prod[32:0];
    end
    if (cmd_i.div_step) begin
      rem_q <= ge ? 32'(rem2 - {1'b0, d_q}) : rem2[31:0];
      qr_q  <= {qr_q[31:0], ge};
    end
    if (cmd_i.fin) res_q <= r_v[31:0];
    if (cmd_i.emit) begin
      out_comp_q   <= comp_q;
      out_val_q    <= res_q;
      out_last_q   <= comp_q == wti_pkg::COMP_TIME;
      out_status_q <= mode_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_component_o = out_comp_q;
  assign out_value_o     = out_val_q;
  assign out_last_o      = out_last_q;
  assign out_status_o    = out_status_q;

endmodule

/* rtl/waypoint_trajectory_interpolator.sv */
// Top level: waypoint table with piecewise linear pose interpolation per sample tick.
// A write or new-goal transfer leaves the block idle; a tick returns 15 results in order, one at a time.
// A tick is accepted, then searches the waypoint times, reads the segment start, updates the held
// point on entry, runs the 33-step divider per interpolated pose word and emits other words as
// they are read; output stalls hold it, and ticks never overlap.
// Reset clears control, point_count, start pose, held point and goal flag, not the memory.
module waypoint_trajectory_interpolator #(
  parameter int unsigned WAYPOINTS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [4:0]   cfg_wdata_i,   // point_count
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // slot[3:0], component[7:4], value[39:8], elapsed[70:40], actual_x..actual_qw[294:71]
  input  logic [295:0] s_axis_tdata,
  input  logic [1:0]   s_axis_tuser,  // action
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [39:0]  m_axis_tdata,  // out_component[3:0], out_value[35:4]
  output logic         m_axis_tlast,
  output logic [1:0]   m_axis_tuser   // status
);

  wti_pkg::cmd_t    cmd;
  wti_pkg::sts_t    sts;
  logic [3:0]       out_comp;
  logic [31:0]      out_val;
  logic [6:0][31:0] actual;

  assign actual = s_axis_tdata[294:71];

  wti_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .sts_i     (sts),
    .s_ready_o (s_axis_tready),
    .cmd_o     (cmd)
  );

  wti_dpath #(
    .WAYPOINTS (WAYPOINTS)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .action_i        (s_axis_tuser),
    .slot_i          (s_axis_tdata[3:0]),
    .component_i     (s_axis_tdata[7:4]),
    .value_i         (s_axis_tdata[39:8]),
    .elapsed_i       (s_axis_tdata[70:40]),
    .actual_i        (actual),
    .out_valid_o     (m_axis_tvalid),
    .out_ready_i     (m_axis_tready),
    .out_component_o (out_comp),
    .out_value_o     (out_val),
    .out_last_o      (m_axis_tlast),
    .out_status_o    (m_axis_tuser)
  );

  assign m_axis_tdata = {4'd0, out_val, out_comp};

endmodule

/* rtl/wti_checker.sv */
// Port-level checks of the interpolator, bound to the top level.
module wti_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [39:0]  m_axis_tdata,
  input logic         m_axis_tlast,
  input logic [1:0]   m_axis_tuser
);

  a_comp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[3:0] <= wti_pkg::COMP_TIME)
    else $error("result component out of range");

  a_last_comp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tlast == (m_axis_tdata[3:0] == wti_pkg::COMP_TIME)))
    else $error("tlast not on final component");

  a_busy_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tlast) |-> !s_axis_tready)
    else $error("input taken in the middle of a tick run");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("stalled result transfer changed");

endmodule

bind waypoint_trajectory_interpolator wti_checker u_wti_checker (.*);

/* bench/testbench.sv */
// Stream-level testbench for the waypoint trajectory interpolator, checked by a scoreboard.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WAYPTS = 16;
  localparam longint LIMIT = 3000000;

  typedef struct {
    logic [3:0]        comp;
    logic [31:0]       value;
    logic              last;
    wti_pkg::status_e  status;
  } sample_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_we_i = 1'b0;
  logic [4:0]   cfg_wdata_i = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [295:0] s_axis_tdata = '0;
  logic [1:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [39:0]  m_axis_tdata;
  logic         m_axis_tlast;
  logic [1:0]   m_axis_tuser;

  waypoint_trajectory_interpolator #(.WAYPOINTS(WAYPTS)) dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // shadow state of the block
  logic [31:0] wp_mem [WAYPTS][16];
  logic [31:0] start_pose [7];
  logic [31:0] held_pt [15];
  logic        goal_fresh;
  logic [4:0]  point_count;

  sample_t     pending_q[$];
  int          errors = 0;
  int          items_sent = 0;
  int          burst_left = 0;
  bit          hold_req = 1'b0;
  longint      cycles = 0;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // receiver stall pattern, with one long hold-off on request
  always @(posedge clk_i) begin
    int mode, win, hold_cnt;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      mode = 0;
      win = 0;
      hold_cnt = 0;
    end else if (hold_req) begin
      m_axis_tready <= 1'b0;
      hold_cnt++;
      if (hold_cnt >= 3000) begin
        hold_req <= 1'b0;
        hold_cnt = 0;
      end
    end else begin
      if (win == 0) begin
        mode = $urandom_range(0, 3);
        win = $urandom_range(8, 80);
      end
      win--;
      case (mode)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= ($urandom_range(0, 1) == 0);
        2: m_axis_tready <= ($urandom_range(0, 3) == 0);
        default: m_axis_tready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  // result checker
  always @(posedge clk_i) begin
    sample_t e;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result comp=%0d value=%h", m_axis_tdata[3:0], m_axis_tdata[35:4]);
      end else begin
        e = pending_q.pop_front();
        if (m_axis_tdata[3:0] !== e.comp || m_axis_tdata[35:4] !== e.value ||
            m_axis_tlast !== e.last || m_axis_tuser !== e.status) begin
          errors++;
          if (errors <= 10)
            $display("mismatch exp comp=%0d val=%h last=%b st=%0d got comp=%0d val=%h %s",
                     e.comp, e.value, e.last, e.status, m_axis_tdata[3:0],
                     m_axis_tdata[35:4], $sformatf("last=%b st=%0d", m_axis_tlast,
                     m_axis_tuser));
        end
      end
    end
  end

  task automatic push_sample(int k, logic [31:0] v, wti_pkg::status_e s);
    sample_t e;
    e.comp = k[3:0];
    e.value = v;
    e.last = (k == wti_pkg::NCOMP - 1);
    e.status = s;
    pending_q.insert(pending_q.size(), e);
  endtask

  task automatic predict_tick(logic [30:0] el, logic [31:0] act [7]);
    int n, i;
    longint t, ts, te, sv, ev, diff, r;
    logic [127:0] num, q;
    logic [63:0] mag;
    wti_pkg::status_e st;
    t = longint'(el);
    n = (point_count > WAYPTS) ? WAYPTS : point_count;
    if (n == 0) begin
      for (int c = 0; c < wti_pkg::NCOMP; c++) push_sample(c, held_pt[c], wti_pkg::ST_EMPTY);
      return;
    end
    if (goal_fresh) begin
      for (int c = 0; c < wti_pkg::NCOMP; c++)
        held_pt[c] = (c < wti_pkg::POSE_N) ? start_pose[c] : '0;
      goal_fresh = 1'b0;
    end
    for (i = 0; i < n; i++)
      if (longint'($signed(wp_mem[i][wti_pkg::COMP_TIME])) >= t) break;
    if (i >= n) begin
      for (int c = 0; c < wti_pkg::NCOMP; c++)
        push_sample(c, wp_mem[n-1][c], wti_pkg::ST_PAST_END);
      return;
    end
    if (i > 0 && held_pt[wti_pkg::COMP_TIME] != wp_mem[i-1][wti_pkg::COMP_TIME]) begin
      for (int c = 0; c < wti_pkg::NCOMP; c++)
        held_pt[c] = (c < wti_pkg::POSE_N) ? act[c] : wp_mem[i-1][c];
    end
    ts = (i > 0) ? longint'($signed(wp_mem[i-1][wti_pkg::COMP_TIME])) : 0;
    te = longint'($signed(wp_mem[i][wti_pkg::COMP_TIME]));
    if (te <= ts) begin
      st = wti_pkg::ST_ZERO_SEG;
      for (int c = 0; c < wti_pkg::POSE_N; c++) push_sample(c, act[c], st);
    end else begin
      st = wti_pkg::ST_INTERP;
      for (int c = 0; c < wti_pkg::POSE_N; c++) begin
        sv = longint'($signed(i == 0 ? start_pose[c] : held_pt[c]));
        ev = longint'($signed(wp_mem[i][c]));
        diff = ev - sv;
        mag = (diff < 0) ? -diff : diff;
        num = 128'(mag) * 128'(t - ts);
        q = num / 128'(te - ts);
        r = (diff < 0) ? sv - longint'(q) : sv + longint'(q);
        push_sample(c, r[31:0], st);
      end
    end
    for (int c = wti_pkg::POSE_N; c < wti_pkg::COMP_TIME; c++) push_sample(c, wp_mem[i][c], st);
    push_sample(wti_pkg::COMP_TIME, {1'b0, el}, st);
  endtask

  task automatic send(wti_pkg::action_e a, logic [3:0] slot, logic [3:0] comp,
                      logic [31:0] val, logic [30:0] el);
    logic [31:0] act [7];
    logic [223:0] act_bits;
    int gap;
    for (int c = 0; c < 7; c++) begin
      act[c] = $urandom;
      act_bits[c*32 +: 32] = act[c];
    end
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      burst_left = $urandom_range(1, 12);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= a;
    s_axis_tdata <= {1'b0, act_bits, el, val, comp, slot};
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
    case (a)
      wti_pkg::ACT_WP_WRITE:
        if (comp < wti_pkg::NCOMP)
          wp_mem[slot][comp] = (comp == wti_pkg::COMP_FLAGS) ? {26'b0, val[5:0]} : val;
      wti_pkg::ACT_START_WRITE: if (comp < wti_pkg::POSE_N) start_pose[comp] = val;
      wti_pkg::ACT_NEW_GOAL: goal_fresh = 1'b1;
      default: predict_tick(el, act);
    endcase
  endtask

  task automatic tick(logic [30:0] el);
    send(wti_pkg::ACT_TICK, '0, '0, '0, el);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic set_count(logic [4:0] v);
    wait_idle();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    point_count = v;
  endtask

  // ascending times; some equal steps give zero-length segments
  task automatic load_times(int max_step);
    logic [31:0] tacc;
    tacc = $urandom_range(0, max_step);
    for (int s = 0; s < WAYPTS; s++) begin
      send(wti_pkg::ACT_WP_WRITE, s[3:0], wti_pkg::COMP_TIME, tacc, '0);
      if ($urandom_range(0, 5) != 0) tacc += $urandom_range(1, max_step);
    end
  endtask

  task automatic load_table();
    for (int s = 0; s < WAYPTS; s++)
      for (int c = 0; c < wti_pkg::NCOMP - 1; c++)
        send(wti_pkg::ACT_WP_WRITE, s[3:0], c[3:0], (s == 3) ? 32'h8000_0000 :
             (s == 4) ? 32'h7FFF_FFFF : $urandom, '0);
    load_times(32'h20000);
    for (int c = 0; c < wti_pkg::POSE_N; c++)
      send(wti_pkg::ACT_START_WRITE, '0, c[3:0], $urandom, '0);
  endtask

  task automatic test_empty_table();
    tick('0);
    send(wti_pkg::ACT_NEW_GOAL, '0, '0, '0, '0);
    tick(31'h7FFF_FFFF);
  endtask

  task automatic test_segments();
    set_count(5'd16);
    send(wti_pkg::ACT_NEW_GOAL, '0, '0, '0, '0);
    tick('0);
    tick(31'(wp_mem[0][wti_pkg::COMP_TIME]) >> 1);
    tick(31'(wp_mem[1][wti_pkg::COMP_TIME]));
    tick(31'(wp_mem[2][wti_pkg::COMP_TIME]) + 31'd1);
    tick(31'(wp_mem[7][wti_pkg::COMP_TIME]));
    tick(31'h7FFF_FFFF);
    send(wti_pkg::ACT_WP_WRITE, 4'd2, wti_pkg::COMP_TIME, wp_mem[1][wti_pkg::COMP_TIME], '0);
    tick(31'(wp_mem[1][wti_pkg::COMP_TIME]) + 31'd1);
    send(wti_pkg::ACT_WP_WRITE, 4'd15, wti_pkg::COMP_TIME, 32'h7FFF_FFFF, '0);
    tick(31'h7FFF_FFFE);
  endtask

  task automatic test_ignored_writes();
    send(wti_pkg::ACT_WP_WRITE, 4'd5, 4'd15, $urandom, '0);
    send(wti_pkg::ACT_START_WRITE, '0, 4'd7, $urandom, '0);
    send(wti_pkg::ACT_START_WRITE, '0, 4'd15, $urandom, '0);
    send(wti_pkg::ACT_WP_WRITE, 4'd0, wti_pkg::COMP_FLAGS, 32'hFFFF_FFFF, '0);
    send(wti_pkg::ACT_NEW_GOAL, '0, '0, '0, '0);
    tick('0);
  endtask

  task automatic test_count_extremes();
    set_count(5'd31);
    tick(31'h7FFF_FFFF);
    set_count(5'd17);
    tick($urandom_range(0, 32'h40000));
    set_count(5'd1);
    send(wti_pkg::ACT_NEW_GOAL, '0, '0, '0, '0);
    tick('0);
    tick(31'h7FFF_FFFF);
    set_count(5'd0);
    tick($urandom);
  endtask

  task automatic test_backpressure();
    set_count(5'd16);
    hold_req = 1'b1;
    for (int k = 0; k < 12; k++) tick(31'h7FFF_FFFF - k);
  endtask

  task automatic test_random();
    int span;
    logic [30:0] el;
    while (items_sent < 330) begin
      case ($urandom_range(0, 7))
        0: set_count($urandom);
        1: set_count(5'd16);
        default: set_count($urandom_range(1, 16));
      endcase
      if ($urandom_range(0, 2) == 0) load_times($urandom_range(1, 32'h30000));
      if ($urandom_range(0, 1) == 0)
        for (int c = 0; c < wti_pkg::POSE_N; c++)
          send(wti_pkg::ACT_START_WRITE, '0, c[3:0], $urandom, '0);
      send(wti_pkg::ACT_NEW_GOAL, '0, '0, '0, '0);
      span = (point_count == 0) ? 1000 :
             wp_mem[(point_count > 16 ? 16 : point_count) - 1][wti_pkg::COMP_TIME];
      if (span <= 0) span = 1000;
      el = '0;
      for (int k = 0; k < $urandom_range(3, 12); k++) begin
        case ($urandom_range(0, 9))
          0: send(wti_pkg::ACT_WP_WRITE, $urandom, $urandom, $urandom, $urandom);
          1: send(wti_pkg::ACT_START_WRITE, '0, $urandom, $urandom, '0);
          2: tick($urandom);
          3: send(wti_pkg::ACT_NEW_GOAL, '0, '0, '0, '0);
          default: begin
            el = el + 31'($urandom_range(0, span / 6 + 1));
            tick(el);
          end
        endcase
      end
    end
  endtask

  initial begin
    for (int c = 0; c < 7; c++) start_pose[c] = '0;
    for (int c = 0; c < wti_pkg::NCOMP; c++) held_pt[c] = '0;
    goal_fresh = 1'b0;
    point_count = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_table();
    load_table();
    test_segments();
    test_ignored_writes();
    test_count_extremes();
    test_backpressure();
    test_random();
    wait_idle();
    repeat (400) @(posedge clk_i);
    if (errors == 0 && pending_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
